// ===== sv/pcc_pkg.sv =====
package pcc_pkg;

    // Default permutation capacity.
    localparam int unsigned MAX_LEN_DEF = 64;

    // Fixed field widths.
    localparam int unsigned TARGET_W = 6;
    localparam int unsigned COUNT_W  = 7;

    // Word widths on the stream ports.
    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 16;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_CHECK,
        ST_FOLLOW,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // store one accepted element
        logic walk_init;  // clear scan position, cycle count and error
        logic scan_rd;    // read the entry at the scan position
        logic skip;       // entry already visited: close a cycle, advance the scan
        logic mark;       // mark the entry visited and step to its target
        logic follow_rd;  // read the entry at the walk position
        logic finish;     // load the result register and start a new load
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;  // scan position reached the loaded length
        logic visited;    // entry just read is already visited
        logic tgt_oob;    // target of the entry just read is out of range
        logic out_busy;   // result register holds a word not yet taken
    } t_status;

endpackage

// ===== sv/pcc_ram.sv =====
module pcc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/pcc_ctrl.sv =====
module pcc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  logic             i_s_tlast,
    output logic             o_s_tready,
    input  pcc_pkg::t_status i_status,
    output pcc_pkg::t_cmd    o_cmd
);

    import pcc_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_s_tvalid && (r_state == ST_LOAD);

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (accept && i_s_tlast) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                n_state = i_status.scan_done ? ST_DONE : ST_CHECK;
            end
            ST_CHECK: begin
                if (i_status.visited) begin
                    n_state = ST_SCAN;
                end else if (i_status.tgt_oob) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_FOLLOW;
                end
            end
            ST_FOLLOW: begin
                n_state = ST_CHECK;
            end
            ST_DONE: begin
                if (!i_status.out_busy) begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // Commands and handshake.
    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                o_s_tready      = 1'b1;
                o_cmd.load      = accept;
                o_cmd.walk_init = accept && i_s_tlast;
            end
            ST_SCAN: begin
                o_cmd.scan_rd = !i_status.scan_done;
            end
            ST_CHECK: begin
                o_cmd.skip = i_status.visited;
                o_cmd.mark = !i_status.visited;
            end
            ST_FOLLOW: begin
                o_cmd.follow_rd = 1'b1;
            end
            ST_DONE: begin
                o_cmd.finish = !i_status.out_busy;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== sv/pcc_datapath.sv =====
module pcc_datapath #(
    parameter int unsigned MAX_LEN = pcc_pkg::MAX_LEN_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [pcc_pkg::TARGET_W-1:0]    i_target_index,
    input  pcc_pkg::t_cmd                   i_cmd,
    output pcc_pkg::t_status                o_status,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [pcc_pkg::COUNT_W-1:0]     o_cycle_total,
    output logic [pcc_pkg::COUNT_W-1:0]     o_changes_needed,
    output logic                            o_range_error
);

    import pcc_pkg::*;

    localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int unsigned LW = $clog2(MAX_LEN + 1);
    localparam int unsigned CW = (LW > TARGET_W) ? LW : TARGET_W;
    localparam int unsigned KW = (LW > COUNT_W) ? LW : COUNT_W;
    localparam int unsigned MW = TARGET_W + 1;

    logic [LW-1:0]      r_len;
    logic [LW-1:0]      r_scan;
    logic [AW-1:0]      r_ptr;
    logic               r_in_walk;
    logic [LW-1:0]      r_cycles;
    logic               r_err;
    logic               r_out_valid;
    logic [COUNT_W-1:0] r_total;
    logic [COUNT_W-1:0] r_changes;
    logic               r_out_err;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [MW-1:0]      ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [MW-1:0]      ram_rdata;

    logic [TARGET_W-1:0] rd_target;
    logic                rd_visited;
    logic [AW+TARGET_W-1:0] tgt_ext;
    logic [AW-1:0]       tgt_addr;
    logic                len_full;
    logic [KW-1:0]       cycles_ext;
    logic [COUNT_W-1:0]  total_masked;

    // Memory word: visited flag above the stored target.
    assign rd_visited = ram_rdata[MW-1];
    assign rd_target  = ram_rdata[TARGET_W-1:0];
    assign tgt_ext    = {{AW{1'b0}}, rd_target};
    assign tgt_addr   = tgt_ext[AW-1:0];
    assign len_full   = (r_len == LW'(MAX_LEN));

    // A load clears the visited flag of every position it writes.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_ptr;
        ram_wdata = {1'b1, rd_target};
        if (i_cmd.load) begin
            ram_we    = !len_full;
            ram_waddr = r_len[AW-1:0];
            ram_wdata = {1'b0, i_target_index};
        end else if (i_cmd.mark) begin
            ram_we = 1'b1;
        end
    end

    assign ram_re    = i_cmd.scan_rd || i_cmd.follow_rd;
    assign ram_raddr = i_cmd.scan_rd ? r_scan[AW-1:0] : r_ptr;

    pcc_ram #(
        .WIDTH (MW),
        .DEPTH (MAX_LEN)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Status toward the controller.
    always_comb begin
        o_status.scan_done = (r_scan == r_len);
        o_status.visited   = rd_visited;
        o_status.tgt_oob   = (CW'(rd_target) >= CW'(r_len));
        o_status.out_busy  = r_out_valid && !i_out_ready;
    end

    // Load length, scan position, walk position and cycle count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_scan    <= '0;
            r_ptr     <= '0;
            r_in_walk <= 1'b0;
            r_cycles  <= '0;
            r_err     <= 1'b0;
        end else begin
            if (i_cmd.load && !len_full) begin
                r_len <= r_len + LW'(1);
            end
            if (i_cmd.walk_init) begin
                r_scan   <= '0;
                r_cycles <= '0;
                r_err    <= 1'b0;
            end
            if (i_cmd.scan_rd) begin
                r_ptr     <= r_scan[AW-1:0];
                r_in_walk <= 1'b0;
            end
            if (i_cmd.skip) begin
                r_scan <= r_scan + LW'(1);
                if (r_in_walk) begin
                    r_cycles <= r_cycles + LW'(1);
                end
            end
            if (i_cmd.mark) begin
                r_ptr     <= tgt_addr;
                r_in_walk <= 1'b1;
                if (o_status.tgt_oob) begin
                    r_err <= 1'b1;
                end
            end
            if (i_cmd.finish) begin
                r_len <= '0;
            end
        end
    end

    // Counts are reported modulo the 7-bit field width.
    assign cycles_ext   = KW'(r_cycles);
    assign total_masked = cycles_ext[COUNT_W-1:0];

    // Result register: valid until the word is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_err <= r_err;
            if (r_err) begin
                r_total   <= '0;
                r_changes <= '0;
            end else begin
                r_total   <= total_masked;
                r_changes <= (r_cycles == LW'(1)) ? '0 : total_masked;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_cycle_total    = r_total;
    assign o_changes_needed = r_changes;
    assign o_range_error    = r_out_err;

endmodule

// ===== sv/permutation_cycle_counter.sv =====
// Channel   Dir  tdata fields (low bit up)                   tlast     tuser
// s         in   target_index[5:0], zero pad [7:6]           is_last   -
// m         out  cycle_total[6:0], changes_needed[13:7],     -         range_error
//                zero pad [15:14]
//
// Each element of a permutation is stored as it is accepted; then each start
// position is scanned and checked and each element followed in a cycle is read
// and checked, until a final scan ends the walk and the result is written, all
// through the one write port and the registered read port of the mapping memory.
// The input is not ready from the last element until the result is written.
// Reset clears the control state; the memory needs no clearing, since each load
// clears the visited flag of every position it stores. The result word stays in
// its register until taken, and the next load is accepted meanwhile.
module permutation_cycle_counter #(
    parameter int unsigned MAX_LEN = pcc_pkg::MAX_LEN_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [pcc_pkg::S_TDATA_W-1:0]  i_s_tdata,   // target_index
    input  logic                           i_s_tlast,   // is_last
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [pcc_pkg::M_TDATA_W-1:0]  o_m_tdata,   // cycle_total, changes_needed
    output logic                           o_m_tuser    // range_error
);

    import pcc_pkg::*;

    t_cmd               cmd;
    t_status            status;
    logic [COUNT_W-1:0] cycle_total;
    logic [COUNT_W-1:0] changes_needed;

    // Sequencer.
    pcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tlast  (i_s_tlast),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Mapping memory, walk registers and result register.
    pcc_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_target_index   (i_s_tdata[TARGET_W-1:0]),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_out_ready      (i_m_tready),
        .o_out_valid      (o_m_tvalid),
        .o_cycle_total    (cycle_total),
        .o_changes_needed (changes_needed),
        .o_range_error    (o_m_tuser)
    );

    // Pack the result word.
    assign o_m_tdata = M_TDATA_W'({changes_needed, cycle_total});

endmodule

// ===== sv/pcc_checker.sv =====
module pcc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        i_s_tlast,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic        o_m_tuser
);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result word changed while stalled");

    // The input is not ready in the cycle after the last element is taken.
    a_walk_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tlast |=> !o_s_tready)
        else $error("input ready right after the last element");

    // A range error reports zero counts.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata[13:0] == 14'd0)
        else $error("range error with nonzero counts");

    // A single cycle needs no changes.
    a_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[6:0] == 7'd1 |-> o_m_tdata[13:7] == 7'd0)
        else $error("single cycle reports changes");

    // Otherwise the change count equals the cycle count.
    a_changes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[6:0] != 7'd1 |-> o_m_tdata[13:7] == o_m_tdata[6:0])
        else $error("change count differs from cycle count");

endmodule

bind permutation_cycle_counter pcc_checker u_pcc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

// ===== tb/sv/pcc_cycle_checker.sv =====
// Watches both stream channels of the permutation cycle counter, keeps its own copy
// of the loaded mapping, predicts the result word of every completed load and
// compares each result word that the block hands over against the oldest prediction.
module pcc_cycle_checker #(
    parameter int unsigned MAX_LEN = pcc_pkg::MAX_LEN_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [pcc_pkg::S_TDATA_W-1:0]  i_s_tdata,   // target_index, zero pad
    input  logic                           i_s_tlast,   // is_last
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [pcc_pkg::M_TDATA_W-1:0]  i_m_tdata,   // cycle_total, changes_needed, pad
    input  logic                           i_m_tuser,   // range_error
    output int                             o_fail_count,
    output int                             o_pending
);

    import pcc_pkg::*;

    typedef struct packed {
        logic [COUNT_W-1:0] cycle_total;
        logic [COUNT_W-1:0] changes_needed;
        logic               range_error;
    } cycle_report_t;

    logic [TARGET_W-1:0] perm_map [MAX_LEN];
    int unsigned         load_len;
    cycle_report_t       report_q [$];
    cycle_report_t       got_report;
    cycle_report_t       want_report;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        load_len     = 0;
    end

    // Follows every cycle of the stored mapping, marking positions as they are
    // visited. A target outside the loaded length stops the walk with an error.
    function automatic cycle_report_t count_cycles(input int unsigned len);
        logic          seen [MAX_LEN];
        int unsigned   cycles;
        int unsigned   pos;
        cycle_report_t rep;
        for (int i = 0; i < MAX_LEN; i++) seen[i] = 1'b0;
        cycles = 0;
        rep    = '0;
        for (int unsigned start = 0; start < len; start++) begin
            if (!seen[start]) begin
                pos = start;
                while (!seen[pos]) begin
                    seen[pos] = 1'b1;
                    if (perm_map[pos] >= len) begin
                        rep.range_error = 1'b1;
                        return rep;
                    end
                    pos = perm_map[pos];
                end
                cycles++;
            end
        end
        rep.cycle_total    = cycles[COUNT_W-1:0];
        rep.changes_needed = (cycles == 1) ? '0 : cycles[COUNT_W-1:0];
        return rep;
    endfunction

    task automatic compare_field(input string name, input int unsigned want_v,
                                 input int unsigned got_v);
        if (want_v !== got_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
            o_fail_count++;
        end
    endtask

    // Result words are checked before the input word of the same edge is taken in,
    // so the queue order always matches the order of the loads.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_m_tvalid && i_m_tready) begin
                got_report.cycle_total    = i_m_tdata[COUNT_W-1:0];
                got_report.changes_needed = i_m_tdata[2*COUNT_W-1:COUNT_W];
                got_report.range_error    = i_m_tuser;
                if (report_q.size() == 0) begin
                    $error("result word with no load pending: tdata=%h tuser=%b",
                           i_m_tdata, i_m_tuser);
                    o_fail_count++;
                end else begin
                    want_report = report_q.pop_front();
                    compare_field("cycle_total", want_report.cycle_total,
                                  got_report.cycle_total);
                    compare_field("changes_needed", want_report.changes_needed,
                                  got_report.changes_needed);
                    compare_field("range_error", want_report.range_error,
                                  got_report.range_error);
                end
            end
            // Elements beyond the capacity are dropped, but a last one still ends the load.
            if (i_s_tvalid && i_s_tready) begin
                if (load_len < MAX_LEN) begin
                    perm_map[load_len] = i_s_tdata[TARGET_W-1:0];
                    load_len++;
                end
                if (i_s_tlast) begin
                    report_q.push_back(count_cycles(load_len));
                    load_len = 0;
                end
            end
            o_pending = report_q.size();
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
// Drives permutation loads into the cycle counter and gives the verdict; the
// checker beside the block predicts and compares every result word.
module tb;

    import pcc_pkg::*;

    localparam int unsigned MAX_LEN      = MAX_LEN_DEF;
    localparam int unsigned BUF_DEPTH    = MAX_LEN + 16;
    localparam int unsigned RANDOM_ITEMS = 1050;
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned DRAIN_CYCLES = 5 * MAX_LEN + 50;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;

    int                    fail_count;
    int                    pending;
    int unsigned           cycle_count;
    int unsigned           items_sent;
    int unsigned           load_count;
    logic                  burst_load;
    logic [TARGET_W-1:0]   load_buf [BUF_DEPTH];
    int unsigned           load_len;
    int unsigned           shuffle_len;
    int unsigned           pick;
    int unsigned           swap_idx;
    logic [TARGET_W-1:0]   swap_tmp;
    int unsigned           ready_hold;
    logic                  ready_next;

    permutation_cycle_counter #(
        .MAX_LEN(MAX_LEN)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    pcc_cycle_checker #(
        .MAX_LEN(MAX_LEN)
    ) u_cycle_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Clock with a period of 10.
    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Runaway guard.
    initial cycle_count = 0;
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: random stretches of ready and stall, mostly short.
    initial begin
        m_tready   = 1'b0;
        ready_hold = 0;
        ready_next = 1'b0;
        forever begin
            @(negedge clk);
            if (ready_hold == 0) begin
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    ready_next = 1'b1;
                    ready_hold = $urandom_range(1, 20);
                end else if (pick < 95) begin
                    ready_next = 1'b0;
                    ready_hold = $urandom_range(1, 4);
                end else begin
                    ready_next = 1'b0;
                    ready_hold = $urandom_range(20, 80);
                end
            end
            ready_hold--;
            m_tready <= ready_next;
        end
    end

    // Sends one element, with a random gap ahead of it unless the load is a burst.
    task automatic send_word(input logic [TARGET_W-1:0] target, input logic last);
        int unsigned gap;
        int unsigned gap_pick;
        gap_pick = $urandom_range(0, 99);
        if (burst_load || gap_pick < 50) gap = 0;
        else if (gap_pick < 90) gap = $urandom_range(1, 3);
        else if (gap_pick < 98) gap = $urandom_range(4, 10);
        else gap = $urandom_range(30, 80);
        @(negedge clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-TARGET_W){1'b0}}, target};
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_load();
        for (int unsigned i = 0; i < load_len; i++)
            send_word(load_buf[i], i == load_len - 1);
    endtask

    task automatic load_small(input int unsigned len, input logic [TARGET_W-1:0] e0,
                              input logic [TARGET_W-1:0] e1, input logic [TARGET_W-1:0] e2);
        load_len    = len;
        load_buf[0] = e0;
        load_buf[1] = e1;
        load_buf[2] = e2;
        send_load();
    endtask

    // Holds the sender off until every predicted result has been handed over.
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    initial begin
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        rst_n      = 1'b0;
        items_sent = 0;
        load_count = 0;
        burst_load = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed loads: single element in and out of range, the identity and a
        // swap of two, a mapping that is not a permutation, a range error after a
        // closed cycle, and one rotation of three.
        load_small(1, 6'd0, 6'd0, 6'd0);
        load_small(1, 6'd63, 6'd0, 6'd0);
        load_small(2, 6'd0, 6'd1, 6'd0);
        load_small(2, 6'd1, 6'd0, 6'd0);
        load_small(2, 6'd1, 6'd1, 6'd0);
        load_small(3, 6'd0, 6'd3, 6'd1);
        load_small(3, 6'd2, 6'd0, 6'd1);
        wait_drained();

        // Random loads: mostly true permutations, some with one element spoiled,
        // some pure noise and a few that run past the capacity.
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            load_count++;
            burst_load = ($urandom_range(0, 9) < 3);
            pick = $urandom_range(0, 99);
            if (pick < 85) load_len = $urandom_range(1, 12);
            else if (pick < 95) load_len = $urandom_range(13, 40);
            else load_len = MAX_LEN;
            pick = $urandom_range(0, 99);
            if (pick >= 95) load_len = MAX_LEN + $urandom_range(1, 8);
            shuffle_len = (load_len < MAX_LEN) ? load_len : MAX_LEN;
            for (int unsigned i = 0; i < load_len; i++)
                load_buf[i] = (i < MAX_LEN) ? i[TARGET_W-1:0] : TARGET_W'($urandom_range(0, 63));
            // The identity is left unshuffled now and then to reach the largest counts.
            if (!(pick < 68 && $urandom_range(0, 4) == 0)) begin
                for (int unsigned i = shuffle_len - 1; i > 0; i--) begin
                    swap_idx           = $urandom_range(0, i);
                    swap_tmp           = load_buf[i];
                    load_buf[i]        = load_buf[swap_idx];
                    load_buf[swap_idx] = swap_tmp;
                end
            end
            if (pick >= 68 && pick < 83) begin
                load_buf[$urandom_range(0, load_len - 1)] = TARGET_W'($urandom_range(0, 63));
            end else if (pick >= 83 && pick < 95) begin
                for (int unsigned i = 0; i < load_len; i++)
                    load_buf[i] = TARGET_W'($urandom_range(0, 63));
            end
            send_load();
            if (load_count % 40 == 0) wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
